/* hdl/scs_pkg.sv */
package scs_pkg;

	localparam int unsigned CFG_INDEX_BITS = 8;
	localparam int unsigned CFG_DATA_BITS  = 16;
	localparam int unsigned LIMIT_BITS     = 15;
	localparam int unsigned SPAN_BITS      = 16;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_OVER_LIMIT = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_LIMIT  = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BLANK_TIME = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_TIME   = 8'd3;

	localparam logic [LIMIT_BITS-1:0] OVER_LIMIT_RST = 15'd1000;
	localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RST  = 15'd95;
	localparam logic [SPAN_BITS-1:0]  BLANK_TIME_RST = 16'd50;
	localparam logic [SPAN_BITS-1:0]  LOW_TIME_RST   = 16'd1000;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CLOSE   = 1'b1;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] over_limit;
		logic [LIMIT_BITS-1:0] low_limit;
		logic [SPAN_BITS-1:0]  blank_time;
		logic [SPAN_BITS-1:0]  low_time;
	} scs_cfg_t;

endpackage

/* hdl/scs_regs.sv */
module scs_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [scs_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  logic [scs_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output scs_pkg::scs_cfg_t                    cfg
);

	scs_pkg::scs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.over_limit <= scs_pkg::OVER_LIMIT_RST;
			cfg_q.low_limit  <= scs_pkg::LOW_LIMIT_RST;
			cfg_q.blank_time <= scs_pkg::BLANK_TIME_RST;
			cfg_q.low_time   <= scs_pkg::LOW_TIME_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				scs_pkg::CFG_OVER_LIMIT: cfg_q.over_limit <= wr_data[scs_pkg::LIMIT_BITS-1:0];
				scs_pkg::CFG_LOW_LIMIT:  cfg_q.low_limit  <= wr_data[scs_pkg::LIMIT_BITS-1:0];
				scs_pkg::CFG_BLANK_TIME: cfg_q.blank_time <= wr_data[scs_pkg::SPAN_BITS-1:0];
				scs_pkg::CFG_LOW_TIME:   cfg_q.low_time   <= wr_data[scs_pkg::SPAN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/supply_current_supervisor.sv */
// Channel   Direction  Handshake             Payload
// item      in         item_valid/item_stall  operation, now_ms, sample
// result    out        result_valid/result_stall  switch_open, over_trip, under_trip,
//                                             blanking, reported_current
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per clock while item_stall is low; each result is held in the result register.
// The supervisor state updates as a request moves from the input register to the
// result register, so back-to-back requests see each other's effect.
// arst_n resets the limits to their defaults and opens the switch.
// A stalled result holds the result register; item_stall rises only while the input
// register is full behind it. cfg_ready is always high.
module supply_current_supervisor #(
	parameter int unsigned TIME_BITS    = 32,
	parameter int unsigned CURRENT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                operation,
	input  logic [TIME_BITS-1:0]                now_ms,
	input  logic signed [CURRENT_BITS-1:0]      sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                switch_open,
	output logic                                over_trip,
	output logic                                under_trip,
	output logic                                blanking,
	output logic signed [CURRENT_BITS-1:0]      reported_current,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [scs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int unsigned CW =
		((CURRENT_BITS > scs_pkg::LIMIT_BITS) ? CURRENT_BITS : scs_pkg::LIMIT_BITS) + 1;

	scs_pkg::scs_cfg_t cfg;

	scs_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	logic                          vld_s1;
	logic                          op_s1;
	logic [TIME_BITS-1:0]          now_s1;
	logic signed [CURRENT_BITS-1:0] sample_s1;

	logic                          vld_s2;
	logic                          open_s2;
	logic                          over_s2;
	logic                          under_s2;
	logic                          blank_s2;
	logic signed [CURRENT_BITS-1:0] rep_s2;

	logic                 open_q;
	logic [TIME_BITS-1:0] close_stamp_q;
	logic                 low_active_q;
	logic [TIME_BITS-1:0] low_stamp_q;

	logic advance;
	logic accept;

	assign advance    = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && vld_s2 && result_stall;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			now_s1    <= now_ms;
			sample_s1 <= sample;
		end
	end

	logic [TIME_BITS-1:0] since_close;
	logic [TIME_BITS-1:0] since_low;
	logic [TIME_BITS-1:0] blank_span;
	logic [TIME_BITS-1:0] low_span;
	logic                 win_old;
	logic signed [CW-1:0] cur_x;
	logic signed [CW-1:0] over_x;
	logic signed [CW-1:0] low_x;
	logic                 check;
	logic                 over_hit;
	logic                 low_hit;
	logic                 under_hit;
	logic                 blank_n;
	logic                 open_n;
	logic                 low_active_n;
	logic                 set_close;
	logic                 set_low;

	always_comb begin
		since_close  = now_s1 - close_stamp_q;
		since_low    = now_s1 - low_stamp_q;
		blank_span   = TIME_BITS'(cfg.blank_time);
		low_span     = TIME_BITS'(cfg.low_time);
		win_old      = !open_q && (since_close < blank_span);
		cur_x        = CW'(sample_s1);
		over_x       = signed'(CW'(cfg.over_limit));
		low_x        = signed'(CW'(cfg.low_limit));
		check        = 1'b0;
		over_hit     = 1'b0;
		low_hit      = 1'b0;
		under_hit    = 1'b0;
		blank_n      = win_old;
		open_n       = open_q;
		low_active_n = low_active_q;
		set_close    = 1'b0;
		set_low      = 1'b0;
		unique case (op_s1)
			scs_pkg::OP_CLOSE: begin
				if (open_q) begin
					open_n       = 1'b0;
					set_close    = 1'b1;
					low_active_n = 1'b0;
					blank_n      = (blank_span != '0);
				end
			end
			default: begin
				check     = !open_q && !win_old;
				over_hit  = check && (cur_x > over_x);
				low_hit   = check && !over_hit && (cur_x < low_x);
				under_hit = low_hit && low_active_q && (since_low >= low_span);
				set_low   = low_hit && !low_active_q;
				open_n    = open_q || over_hit || under_hit;
				if (low_hit) begin
					low_active_n = 1'b1;
				end else if (check && !over_hit) begin
					low_active_n = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 1'b1;
			close_stamp_q <= '0;
			low_active_q  <= 1'b0;
			low_stamp_q   <= '0;
		end else if (advance) begin
			open_q       <= open_n;
			low_active_q <= low_active_n;
			if (set_close) begin
				close_stamp_q <= now_s1;
			end
			if (set_low) begin
				low_stamp_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			open_s2  <= open_n;
			over_s2  <= over_hit;
			under_s2 <= under_hit;
			blank_s2 <= blank_n;
			rep_s2   <= blank_n ? '0 : sample_s1;
		end
	end

	assign result_valid     = vld_s2;
	assign switch_open      = open_s2;
	assign over_trip        = over_s2;
	assign under_trip       = under_s2;
	assign blanking         = blank_s2;
	assign reported_current = rep_s2;

	a_one_trip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(over_trip && under_trip))
		else $error("both trip causes reported for one result");

	a_trip_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (over_trip || under_trip)) |-> switch_open)
		else $error("trip reported with switch still closed");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && blanking) |-> (!switch_open && reported_current == '0))
		else $error("blanking result with open switch or nonzero current");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && vld_s1))
		else $error("input stalled without a blocked result");

	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> (switch_open == open_q))
		else $error("result switch state differs from supervisor state");

endmodule
